FILE: src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, action and status codes and the cell command struct
// for the circular deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int CDQ_DEPTH      = 16;
    localparam int CDQ_DATA_WIDTH = 32;
    localparam int CDQ_ACT_W      = 3;
    localparam int CDQ_STATUS_W   = 2;

    typedef enum logic [CDQ_ACT_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_READ       = 3'd4
    } cdq_action_t;

    typedef enum logic [CDQ_STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } cdq_status_t;

    // One command broadcast to every cell per cycle; at most one flag is set.
    typedef struct packed {
        logic shift_r;    // push front: every cell takes its left neighbour
        logic shift_l;    // pop front: every cell takes its right neighbour
        logic put_tail;   // the cell at the tail position takes the value
    } cdq_cell_cmd_t;

endpackage

`default_nettype wire

FILE: src/circular_deque_top.sv
// ----------------------------------------------------------------------------
// circular_deque_top - double-ended queue on a chain of storage cells
// Result valid in the cycle after the input is taken; one action per cycle
// sustained while the sink keeps up, set by the shift/write of the cell chain.
// Reset: aresetn (sync, active low) empties the deque and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_top #(
    parameter int DEPTH      = cdq_pkg::CDQ_DEPTH,
    parameter int DATA_WIDTH = cdq_pkg::CDQ_DATA_WIDTH,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((DATA_WIDTH + IDX_W + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + cdq_pkg::CDQ_STATUS_W + CNT_W + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [IN_W-1:0]               s_axis_tdata,  // value, index
    input  wire logic [cdq_pkg::CDQ_ACT_W-1:0] s_axis_tuser,  // action
    // result channel
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [OUT_W-1:0]              m_axis_tdata   // data, status, count
);
    import cdq_pkg::*;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    cdq_action_t           act;
    logic [DATA_WIDTH-1:0] in_value;
    logic [IDX_W-1:0]      in_index;
    logic                  in_xfer;

    assign act      = cdq_action_t'(s_axis_tuser);
    assign in_value = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_index = s_axis_tdata[DATA_WIDTH +: IDX_W];

    // Take a new transaction whenever the output stage is free or draining.
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Element count: the front element always sits in cell 0, the back
    // element in cell count-1.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;
    logic             is_full;
    logic             is_empty;
    logic             idx_past;

    assign count_dec = count_reg - CNT_W'(1);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign idx_past  = (CNT_W'(in_index) >= count_reg);

    // ------------------------------------------------------------------
    // Action decode: chain command, read address and result status
    // ------------------------------------------------------------------
    cdq_cell_cmd_t op_cmd;
    cdq_cell_cmd_t cell_cmd;
    cdq_status_t   res_status;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic [CNT_W-1:0] op_count;

    always_comb begin
        op_cmd     = '0;
        res_status = ST_OK;
        rd_addr    = '0;
        rd_en      = 1'b0;
        op_count   = count_reg;
        unique case (act)
            ACT_PUSH_BACK: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    op_cmd.put_tail = 1'b1;
                    op_count        = count_reg + CNT_W'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    op_cmd.shift_r = 1'b1;
                    op_count       = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_BACK: begin
                if (is_empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_addr  = count_dec[IDX_W-1:0];
                    rd_en    = 1'b1;
                    op_count = count_dec;
                end
            end
            ACT_POP_FRONT: begin
                if (is_empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    op_cmd.shift_l = 1'b1;
                    rd_en          = 1'b1;
                    op_count       = count_dec;
                end
            end
            ACT_READ: begin
                if (idx_past) begin
                    res_status = ST_RANGE;
                end else begin
                    rd_addr = in_index;
                    rd_en   = 1'b1;
                end
            end
            default: begin
                // unused action codes: leave everything as it is
            end
        endcase
    end

    // Hold the chain unless a transaction is taken this cycle.
    assign cell_cmd   = in_xfer ? op_cmd : '0;
    assign count_next = in_xfer ? op_count : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 is the front; its left input is the pushed value
    // and the last cell recirculates its own contents on a front pop.
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = in_value;
        end else begin : g_mid_l
            assign left_in = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_in = cell_data[g];
        end else begin : g_mid_r
            assign right_in = cell_data[g+1];
        end

        cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .POS        (g)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .count      (count_reg),
            .rd_addr    (rd_addr),
            .value      (in_value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g]),
            .tap        (cell_tap[g])
        );
    end

    // Combine the read taps; only the addressed cell drives a non-zero word.
    logic [DATA_WIDTH-1:0] rd_data;

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_data = rd_data | cell_tap[i];
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the result until the sink takes it
    // ------------------------------------------------------------------
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [DATA_WIDTH-1:0] m_data_reg;
    logic [DATA_WIDTH-1:0] m_data_next;
    cdq_status_t           m_status_reg;
    cdq_status_t           m_status_next;
    logic [CNT_W-1:0]      m_count_reg;
    logic [CNT_W-1:0]      m_count_next;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        if (in_xfer) begin
            m_valid_next  = 1'b1;
            m_data_next   = rd_en ? rd_data : '0;
            m_status_next = res_status;
            m_count_next  = op_count;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_axis_tvalid = m_valid_reg;

    // Pack data, status and count from the lowest bit up; pad with zeros.
    always_comb begin
        m_axis_tdata                                        = '0;
        m_axis_tdata[DATA_WIDTH-1:0]                        = m_data_reg;
        m_axis_tdata[DATA_WIDTH +: CDQ_STATUS_W]            = m_status_reg;
        m_axis_tdata[DATA_WIDTH + CDQ_STATUS_W +: CNT_W]    = m_count_reg;
    end

endmodule

`default_nettype wire

FILE: src/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque chain: holds one element, shifts towards
// either neighbour and drives a read tap when addressed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell #(
    parameter int DATA_WIDTH = cdq_pkg::CDQ_DATA_WIDTH,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int POS        = 0
) (
    input  wire logic                  aclk,
    input  wire cdq_pkg::cdq_cell_cmd_t cmd,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [IDX_W-1:0]      rd_addr,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic      [DATA_WIDTH-1:0] data,
    output logic      [DATA_WIDTH-1:0] tap
);
    import cdq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_tail;

    assign at_tail = (count == CNT_W'(POS));

    always_comb begin
        if (cmd.shift_r) begin
            data_next = left_data;
        end else if (cmd.shift_l) begin
            data_next = right_data;
        end else if (cmd.put_tail && at_tail) begin
            data_next = value;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // zero unless addressed, so the taps can be OR-combined
    assign tap  = (rd_addr == IDX_W'(POS)) ? data_reg : '0;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for circular_deque_top
// A directed opening covers the empty, full and out-of-range cases, the
// value extremes and the unused action codes. Random phases then fill,
// drain and churn the deque. A scoreboard class predicts each result.
// Both channels idle at random, with some phases running without gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cdq_pkg::*;

    localparam int DEPTH   = CDQ_DEPTH;
    localparam int DATA_W  = CDQ_DATA_WIDTH;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IN_W    = ((DATA_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_W   = ((DATA_W + CDQ_STATUS_W + CNT_W + 7) / 8) * 8;

    // Action codes outside the defined set; the block must ignore them
    localparam logic [CDQ_ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [CDQ_ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_WAIT     = 5;    // longest gap or stall per transaction
    localparam int QUIET_LIMIT  = 200;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 4;    // settle time after the last result

    typedef struct {
        logic [DATA_W-1:0] data;
        cdq_status_t       status;
        logic [CNT_W-1:0]  count;
    } deque_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the ring, head and fill level,
    // queues the result each accepted action should produce and compares
    // every result transaction against the oldest entry.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [DATA_W-1:0] ring [DEPTH];
        int                head;
        int                fill;
        deque_result_t     expected_results [$];
        int                errors;

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
            foreach (ring[k]) ring[k] = '0;
        endfunction

        function int slot_of(int logical);
            return (head + logical) % DEPTH;
        endfunction

        function void note_action(logic [CDQ_ACT_W-1:0] act, logic [DATA_W-1:0] val,
                                  logic [IDX_W-1:0] idx);
            deque_result_t r;
            r.data   = '0;
            r.status = ST_OK;
            case (act)
                ACT_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        ring[slot_of(fill)] = val;
                        fill++;
                    end
                end
                ACT_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = val;
                        fill++;
                    end
                end
                ACT_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data = ring[slot_of(fill - 1)];
                        fill--;
                    end
                end
                ACT_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data = ring[head];
                        head   = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                ACT_READ: begin
                    if (int'(idx) >= fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.data = ring[slot_of(int'(idx))];
                    end
                end
                default: ;  // unused codes leave everything untouched
            endcase
            r.count = CNT_W'(fill);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(logic [OUT_W-1:0] word);
            deque_result_t     exp_r;
            logic [DATA_W-1:0] got_data;
            logic [1:0]        got_status;
            logic [CNT_W-1:0]  got_count;
            got_data   = word[DATA_W-1:0];
            got_status = word[DATA_W +: CDQ_STATUS_W];
            got_count  = word[DATA_W + CDQ_STATUS_W +: CNT_W];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: data %h status %0d count %0d",
                         $time, got_data, got_status, got_count);
                errors++;
                return;
            end
            exp_r = expected_results[0];
            expected_results.delete(0);
            if (got_data !== exp_r.data) begin
                $display("%0t: data mismatch: expected %h, actual %h",
                         $time, exp_r.data, got_data);
                errors++;
            end
            if (got_status !== exp_r.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp_r.status, got_status);
                errors++;
            end
            if (got_count !== exp_r.count) begin
                $display("%0t: count mismatch: expected %0d, actual %0d",
                         $time, exp_r.count, got_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;   // value, index
    logic [CDQ_ACT_W-1:0] s_axis_tuser  = '0;   // action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // data, status, count

    // Phases in which one side runs flat out, without any idling
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;

    int quiet_cycles = 0;

    deque_scoreboard sb = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    circular_deque_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Input side: idle for a random number of cycles, then present the
    // action and hold it until the transaction completes. tvalid is only
    // lowered when a gap follows, so back-to-back actions keep it high.
    // ------------------------------------------------------------------------
    task automatic send_action(logic [CDQ_ACT_W-1:0] act, logic [DATA_W-1:0] val,
                               logic [IDX_W-1:0] idx);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({idx, val});
        s_axis_tuser  <= act;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_action(act, val, idx);
    endtask

    // Favour the extremes of the value range now and then
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return DATA_W'($urandom);
    endfunction

    // One random phase; push_pct steers the deque towards full or empty
    task automatic random_phase(int n_items, int push_pct);
        int                   r;
        int                   fill_now;
        logic [CDQ_ACT_W-1:0] act;
        logic [IDX_W-1:0]     idx;
        for (int i = 0; i < n_items; i++) begin
            r        = $urandom_range(0, 99);
            fill_now = sb.fill;
            idx      = IDX_W'($urandom);
            if (r < 3) begin
                act = CDQ_ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            end else if (r < 22) begin
                act = ACT_READ;
                // mostly valid positions, the rest anywhere in the index range
                if (fill_now > 0 && $urandom_range(0, 3) != 0)
                    idx = IDX_W'($urandom_range(0, fill_now - 1));
            end else if ($urandom_range(0, 99) < push_pct) begin
                act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            end else begin
                act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
            end
            send_action(act, pick_value(), idx);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, then accept one result and check it
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int kind;
        int len;
        sent = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty deque: read, and both pops, must all be refused
        send_action(ACT_READ, pick_value(), '0);
        send_action(ACT_POP_BACK, pick_value(), IDX_W'($urandom));
        send_action(ACT_POP_FRONT, pick_value(), IDX_W'($urandom));
        // Value extremes at both ends, read back by position
        send_action(ACT_PUSH_BACK, '0, IDX_W'($urandom));
        send_action(ACT_PUSH_FRONT, '1, IDX_W'($urandom));
        send_action(ACT_READ, pick_value(), IDX_W'(1));
        // Unused codes: no change, zero data
        send_action(ACT_UNUSED_FIRST, '1, '1);
        send_action(ACT_UNUSED_FIRST + 3'd1, DATA_W'($urandom), IDX_W'($urandom));
        send_action(ACT_UNUSED_LAST, '1, '0);
        // Fill to the brim from both ends, then overfill from both ends
        for (int i = 0; i < DEPTH - 2; i++)
            send_action((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                        DATA_W'($urandom), IDX_W'($urandom));
        send_action(ACT_PUSH_BACK, '1, IDX_W'($urandom));
        send_action(ACT_PUSH_FRONT, '0, IDX_W'($urandom));
        send_action(ACT_READ, pick_value(), '1);
        send_action(ACT_POP_FRONT, pick_value(), IDX_W'($urandom));
        send_action(ACT_POP_BACK, pick_value(), IDX_W'($urandom));

        // Random phases: fill-heavy, drain-heavy or balanced churn
        while (sent < RANDOM_ITEMS) begin
            kind        = $urandom_range(0, 2);
            len         = $urandom_range(20, 40);
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            case (kind)
                0:       random_phase(len, 80);
                1:       random_phase(len, 20);
                default: random_phase(len, 50);
            endcase
            sent += len;
        end

        // Drop tvalid, wait for the last results, then let the block settle
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/cdq_pkg.sv
src/cdq_cell.sv
src/circular_deque_top.sv
tb/tb.sv
